// ----- hdl/fosl_pkg.sv -----
// Package for the frequency-ordered search list: widths, codes and shared types.
`default_nettype none
package fosl_pkg;

  // Table depth default and fixed field widths
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_W           = 32;
  localparam int HITS_W          = 32;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int POS_W           = 6;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic             wr_en;    // write the key at the indexed tail cell
    logic             start;    // inject the search token into the head cell
    logic             scan;     // search token is walking the chain
    logic             promote;  // promoted entry is bubbling toward the head
    logic [KEY_W-1:0] key;      // key to write or search for
  } fosl_ctrl_t;

  // Status returned by each cell
  typedef struct packed {
    logic found;     // token holder matched the key this cycle
    logic swap_req;  // hot entry swaps with its predecessor this cycle
    logic hot;       // cell holds the entry being promoted
    logic tok;       // cell holds the search token
  } fosl_cell_st_t;

endpackage
`default_nettype wire

// ----- hdl/fosl_in_if.sv -----
// Request channel: valid/ready handshake carrying opcode and key.
`default_nettype none
interface fosl_in_if
  import fosl_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output opcode, output key_value, input ready);
  modport sink   (input valid, input opcode, input key_value, output ready);
endinterface
`default_nettype wire

// ----- hdl/fosl_out_if.sv -----
// Result channel: valid/ready handshake carrying status and position.
`default_nettype none
interface fosl_out_if
  import fosl_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface
`default_nettype wire

// ----- hdl/fosl_cell.sv -----
// One table cell: holds a key and hit count, passes the search token and swaps with neighbours.
`default_nettype none
module fosl_cell
  import fosl_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fosl_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire logic [KEY_W-1:0]  prev_key,
  input  wire logic [HITS_W-1:0] prev_hits,
  input  wire logic [KEY_W-1:0]  next_key,
  input  wire logic [HITS_W-1:0] next_hits,
  input  wire logic              pass_in,
  input  wire logic              swap_up_in,
  output logic [KEY_W-1:0]       key_o,
  output logic [HITS_W-1:0]      hits_o,
  output logic                   pass_out,
  output fosl_cell_st_t          st
);

  localparam logic HAS_PREV = (INDEX != 0);

  logic [KEY_W-1:0]  key;
  logic [HITS_W-1:0] hits;
  logic              tok;
  logic              hot;
  logic              hot_next;
  logic              key_eq;
  logic              found;
  logic              swap_req;
  logic              wr_here;
  logic [HITS_W-1:0] hits_inc;

  // Local compare and decisions
  assign key_eq   = (key == ctrl.key);
  assign found    = ctrl.scan && tok && key_eq;
  assign pass_out = ctrl.scan && tok && !key_eq;
  assign swap_req = HAS_PREV && ctrl.promote && hot && (prev_hits < hits);
  assign wr_here  = ctrl.wr_en && (wr_idx == IDX_W'(INDEX));
  assign hits_inc = (hits == '1) ? hits : hits + HITS_W'(1);

  // Hand the promoted mark forward along with the entry
  always_comb begin
    if (found) begin
      hot_next = 1'b1;
    end else if (ctrl.promote) begin
      if (swap_up_in) begin
        hot_next = 1'b1;
      end else if (swap_req) begin
        hot_next = 1'b0;
      end else begin
        hot_next = hot;
      end
    end else begin
      hot_next = 1'b0;
    end
  end

  // Token and promotion mark
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
      hot <= 1'b0;
    end else begin
      tok <= pass_in;
      hot <= hot_next;
    end
  end

  // Entry payload: write, count a hit, or swap with a neighbour
  always_ff @(posedge clk) begin
    if (wr_here) begin
      key  <= ctrl.key;
      hits <= '0;
    end else if (found) begin
      hits <= hits_inc;
    end else if (swap_req) begin
      key  <= prev_key;
      hits <= prev_hits;
    end else if (swap_up_in) begin
      key  <= next_key;
      hits <= next_hits;
    end
  end

  assign key_o       = key;
  assign hits_o      = hits;
  assign st.found    = found;
  assign st.swap_req = swap_req;
  assign st.hot      = hot;
  assign st.tok      = tok;

endmodule
`default_nettype wire

// ----- hdl/frequency_ordered_search_list_top.sv -----
// Top level of the frequency-ordered search list: sequencer, result register and cell chain.
//
//  channel | dir | payload                       | accepted when
//  req     | in  | opcode[1:0], key_value[31:0]  | req.valid && req.ready
//  rsp     | out | status[1:0], position[5:0]    | rsp.valid && rsp.ready
//
// Append, clear and the unused opcode finish without leaving the idle state; the
// result shows on the next cycle. A lookup walks a token down the cell chain one
// cell per cycle; on a hit it then bubbles the hit entry toward the head one swap
// per cycle while the entry in front has fewer hits. Synchronous reset empties
// the table at once.
// A new request is taken while the sequencer is idle and the result register
// is empty or being drained.
`default_nettype none
module frequency_ordered_search_list_top
  import fosl_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  fosl_in_if.sink  req,
  fosl_out_if.source rsp
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TOT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_PROMOTE = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_next;
  logic [IDX_W-1:0]    count;
  logic [IDX_W-1:0]    count_next;
  logic [KEY_W-1:0]    skey;
  logic                out_valid;
  logic                out_valid_next;
  logic [STATUS_W-1:0] out_status;
  logic [STATUS_W-1:0] out_status_next;
  logic [POS_W-1:0]    out_pos;
  logic [POS_W-1:0]    out_pos_next;

  logic       accept;
  logic       full;
  fosl_ctrl_t ctrl;

  logic [KEY_W-1:0]  key_a  [MAX_ENTRIES];
  logic [HITS_W-1:0] hits_a [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] pass_vec;
  logic [MAX_ENTRIES-1:0] found_vec;
  logic [MAX_ENTRIES-1:0] swap_vec;
  logic [MAX_ENTRIES-1:0] hot_vec;
  logic [MAX_ENTRIES-1:0] tok_vec;
  fosl_cell_st_t          st_a [MAX_ENTRIES];

  // Handshake
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (total >= TOT_W'(MAX_ENTRIES));

  // Broadcast to the cells
  always_comb begin
    ctrl.wr_en   = accept && (req.opcode == OP_APPEND) && !full;
    ctrl.start   = accept && (req.opcode == OP_LOOKUP) && (total != '0);
    ctrl.scan    = (state == ST_SCAN);
    ctrl.promote = (state == ST_PROMOTE);
    ctrl.key     = (state == ST_IDLE) ? req.key_value : skey;
  end

  // Sequencer and result register
  always_comb begin
    state_next      = state;
    total_next      = total;
    count_next      = count;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_pos_next    = out_pos;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          out_status_next = STATUS_OK;
          out_pos_next    = '0;
          unique case (req.opcode)
            OP_APPEND: begin
              if (full) begin
                out_status_next = STATUS_FULL;
              end else begin
                out_pos_next = POS_W'(total);
                total_next   = total + TOT_W'(1);
              end
            end
            OP_LOOKUP: begin
              if (total == '0) begin
                out_status_next = STATUS_MISSING;
              end else begin
                out_valid_next = 1'b0;
                count_next     = '0;
                state_next     = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              total_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (|found_vec) begin
          out_valid_next  = 1'b1;
          out_status_next = STATUS_OK;
          out_pos_next    = POS_W'(count);
          state_next      = ST_PROMOTE;
        end else if ((TOT_W'(count) + TOT_W'(1)) == total) begin
          out_valid_next  = 1'b1;
          out_status_next = STATUS_MISSING;
          out_pos_next    = '0;
          state_next      = ST_IDLE;
        end else begin
          count_next = count + IDX_W'(1);
        end
      end
      ST_PROMOTE: begin
        if (!(|swap_vec)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    count      <= count_next;
    out_status <= out_status_next;
    out_pos    <= out_pos_next;
    if (ctrl.start) begin
      skey <= req.key_value;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.position = out_pos;

  // Cell chain
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]  prev_key;
    logic [HITS_W-1:0] prev_hits;
    logic [KEY_W-1:0]  next_key;
    logic [HITS_W-1:0] next_hits;
    logic              pass_in;
    logic              swap_up_in;

    if (i == 0) begin : g_head
      assign prev_key  = '0;
      assign prev_hits = '0;
      assign pass_in   = ctrl.start;
    end else begin : g_body
      assign prev_key  = key_a[i-1];
      assign prev_hits = hits_a[i-1];
      assign pass_in   = pass_vec[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_key   = '0;
      assign next_hits  = '0;
      assign swap_up_in = 1'b0;
    end else begin : g_inner
      assign next_key   = key_a[i+1];
      assign next_hits  = hits_a[i+1];
      assign swap_up_in = swap_vec[i+1];
    end

    fosl_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .wr_idx     (IDX_W'(total)),
      .prev_key   (prev_key),
      .prev_hits  (prev_hits),
      .next_key   (next_key),
      .next_hits  (next_hits),
      .pass_in    (pass_in),
      .swap_up_in (swap_up_in),
      .key_o      (key_a[i]),
      .hits_o     (hits_a[i]),
      .pass_out   (pass_vec[i]),
      .st         (st_a[i])
    );

    assign found_vec[i] = st_a[i].found;
    assign swap_vec[i]  = st_a[i].swap_req;
    assign hot_vec[i]   = st_a[i].hot;
    assign tok_vec[i]   = st_a[i].tok;
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TOT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one search token in the chain");

  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hot_vec))
    else $error("more than one entry marked for promotion");

  a_swap_only_promote: assert property (@(posedge clk) disable iff (rst)
    (state != ST_PROMOTE) |-> (swap_vec == '0))
    else $error("swap outside promotion");

  a_found_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && (|found_vec)) |=> (out_valid && state == ST_PROMOTE))
    else $error("hit did not raise a result");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the frequency-ordered search list: directed rows, random sequences.
`timescale 1ns / 100ps
module tb_top;
  import fosl_pkg::*;

  localparam int DEPTH        = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int TAIL_CYCLES  = 2 * DEPTH + 8;

  // Opcode three is left unused by the block
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } dir_row_t;

  // Directed rows: a typed result is used where the answer is obvious
  localparam int DIR_ROWS = 20;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_LOOKUP, 32'h0000_0000, 1'b1, STATUS_MISSING, 6'd0},
    '{OP_SPARE,  32'hFFFF_FFFF, 1'b1, STATUS_OK,      6'd0},
    '{OP_APPEND, 32'h8000_0000, 1'b1, STATUS_OK,      6'd0},
    '{OP_APPEND, 32'h7FFF_FFFF, 1'b1, STATUS_OK,      6'd1},
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b1, STATUS_OK,      6'd2},
    '{OP_APPEND, 32'h0000_0000, 1'b1, STATUS_OK,      6'd3},
    '{OP_APPEND, 32'h7FFF_FFFF, 1'b1, STATUS_OK,      6'd4},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 1'b1, STATUS_OK,      6'd1},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 1'b0, STATUS_OK,      6'd0},
    '{OP_LOOKUP, 32'h0000_0000, 1'b0, STATUS_OK,      6'd0},
    '{OP_LOOKUP, 32'h0000_0000, 1'b0, STATUS_OK,      6'd0},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, STATUS_OK,      6'd0},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 1'b0, STATUS_OK,      6'd0},
    '{OP_LOOKUP, 32'h1234_5678, 1'b1, STATUS_MISSING, 6'd0},
    '{OP_SPARE,  32'h5555_AAAA, 1'b1, STATUS_OK,      6'd0},
    '{OP_CLEAR,  32'hAAAA_5555, 1'b1, STATUS_OK,      6'd0},
    '{OP_LOOKUP, 32'h8000_0000, 1'b1, STATUS_MISSING, 6'd0},
    '{OP_APPEND, 32'h0000_0001, 1'b1, STATUS_OK,      6'd0},
    '{OP_LOOKUP, 32'h0000_0001, 1'b1, STATUS_OK,      6'd0},
    '{OP_CLEAR,  32'h0000_0000, 1'b1, STATUS_OK,      6'd0}
  };

  logic clk;
  logic rst;

  fosl_in_if  req_if ();
  fosl_out_if rsp_if ();

  frequency_ordered_search_list_top #(
    .MAX_ENTRIES(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Shadow copy of the list, in the block's own order
  logic [KEY_W-1:0]  list_key  [DEPTH];
  logic [HITS_W-1:0] list_hits [DEPTH];
  int                list_count;

  result_t pending_results [$];
  result_t oldest_result;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      phase_items;
  int      send_idle_pct;
  int      recv_stall_pct;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Work out the result of one request and update the shadow list
  function automatic result_t search_list_update(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] key);
    result_t           res;
    int                idx;
    logic [KEY_W-1:0]  k;
    logic [HITS_W-1:0] h;
    res.status   = STATUS_OK;
    res.position = '0;
    case (op)
      OP_APPEND: begin
        if (list_count >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          list_key[list_count]  = key;
          list_hits[list_count] = '0;
          res.position          = list_count[POS_W-1:0];
          list_count++;
        end
      end
      OP_LOOKUP: begin
        idx = 0;
        while (idx < list_count && list_key[idx] != key) idx++;
        if (idx == list_count) begin
          res.status = STATUS_MISSING;
        end else begin
          res.position = idx[POS_W-1:0];
          if (list_hits[idx] != '1) list_hits[idx]++;
          // Bubble toward the head while the entry in front has fewer hits
          while (idx > 0 && list_hits[idx-1] < list_hits[idx]) begin
            k               = list_key[idx];
            h               = list_hits[idx];
            list_key[idx]   = list_key[idx-1];
            list_hits[idx]  = list_hits[idx-1];
            list_key[idx-1] = k;
            list_hits[idx-1] = h;
            idx--;
          end
        end
      end
      OP_CLEAR: begin
        list_count = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Offer one request, idling first at random, and log its result on acceptance
  task automatic drive_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input bit typed = 1'b0, input result_t typed_res = '0);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.key_value <= key;
    do @(posedge clk); while (!req_if.ready);
    res = search_list_update(op, key);
    pending_results.push_back(typed ? typed_res : res);
    phase_items++;
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One well-formed sequence: clear, fill, then a run of mostly hitting lookups
  task automatic run_sequence();
    logic [KEY_W-1:0] used_keys [$];
    logic [KEY_W-1:0] k;
    int               fill;
    int               pick;
    int               a;
    int               b;
    drive_request(OP_CLEAR, $urandom());
    fill = ($urandom_range(5) == 0) ? DEPTH : $urandom_range(1, 16);
    for (int i = 0; i < fill; i++) begin
      if (used_keys.size() != 0 && $urandom_range(7) == 0)
        k = used_keys[$urandom_range(used_keys.size() - 1)];
      else
        k = $urandom();
      used_keys.push_back(k);
      drive_request(OP_APPEND, k);
    end
    // Push past a full table now and then
    if (fill == DEPTH) begin
      repeat ($urandom_range(1, 3)) drive_request(OP_APPEND, $urandom());
    end
    repeat ($urandom_range(10, 40)) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        a = $urandom_range(used_keys.size() - 1);
        b = $urandom_range(used_keys.size() - 1);
        // Favour entries near the tail half the time so they climb
        if ($urandom_range(1) == 0 && b > a) a = b;
        drive_request(OP_LOOKUP, used_keys[a]);
      end else if (pick < 93) begin
        drive_request(OP_LOOKUP, $urandom());
      end else if (pick < 97) begin
        drive_request(OP_APPEND, $urandom());
      end else begin
        drive_request(OP_SPARE, $urandom());
      end
    end
  endtask

  // Result side: stall at random and check each result against the oldest expectation
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d position %0d", rsp_if.status, rsp_if.position);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_if.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.position !== oldest_result.position) begin
          $error("position: expected %0d, got %0d", oldest_result.position, rsp_if.position);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus
  initial begin
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.opcode    = OP_APPEND;
    req_if.key_value = '0;
    list_count       = 0;
    phase_items      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      drive_request(DIRECTED[r].op, DIRECTED[r].key, DIRECTED[r].typed,
                    '{status: DIRECTED[r].status, position: DIRECTED[r].position});
    end
    wait_drained();

    // Random sequences over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / 4) run_sequence();
      wait_drained();
    end

    // Let any stray result show before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/fosl_pkg.sv
hdl/fosl_in_if.sv
hdl/fosl_out_if.sv
hdl/fosl_cell.sv
hdl/frequency_ordered_search_list_top.sv
tb/sv/tb_top.sv
